### rtl/core/uvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// shared widths, register map, arctangent table and helpers for the
// uv sphere vertex generator
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int COUNT_W          = 11;
  localparam int MAX_DIVISIONS    = 1024;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int TEX_W            = 17;
  localparam int NORM_W           = 16;
  localparam int POS_W            = 17;
  localparam int ID_W             = 21;
  localparam int RAD_W            = 16;
  localparam int PHASE_W          = 32;
  localparam int CW               = 34;
  localparam int PROD_W           = 33;
  localparam int ADDR_W           = 4;
  localparam int DATA_W           = 32;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] NORM_ONE    = 34'sd16384;

  typedef enum logic [1:0] {
    REG_RADIUS   = 2'd0,
    REG_SEGMENTS = 2'd1,
    REG_RINGS    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic            in_grid;
    logic            quad;
    logic [ID_W-1:0] vid;
    logic [ID_W-1:0] below;
  } side_t;

  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    if (c == '0) begin
      r = COUNT_W'(1);
    end else if (c > COUNT_W'(MAX_DIVISIONS)) begin
      r = COUNT_W'(MAX_DIVISIONS);
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic signed [NORM_W-1:0] clamp_norm(input logic signed [CW-1:0] v);
    logic signed [NORM_W-1:0] r;
    if (v > NORM_ONE) begin
      r = NORM_W'(NORM_ONE);
    end else if (v < -NORM_ONE) begin
      r = NORM_W'(-NORM_ONE);
    end else begin
      r = v[NORM_W-1:0];
    end
    return r;
  endfunction

  // arctangent of 2^-i in fractions of a full turn, 2^32 per turn
  function automatic logic signed [CW-1:0] atan_turn(input int idx);
    logic signed [CW-1:0] r;
    case (idx)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/uv_sphere_vertex_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// throughput: one vertex per cycle while the output is not stalled, set
// by the fully pipelined divider, cordic and multiplier stages
// reset: synchronous active-low rst_n clears the pipeline valid bits and out_valid,
// and loads radius 1.0, 32 segments and 16 rings
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator
  import uvs_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [COUNT_W-1:0]       in_seg_index,
  input  logic [COUNT_W-1:0]       in_ring_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [POS_W-1:0]  out_pos_x,
  output logic signed [POS_W-1:0]  out_pos_y,
  output logic signed [POS_W-1:0]  out_pos_z,
  output logic signed [NORM_W-1:0] out_norm_x,
  output logic signed [NORM_W-1:0] out_norm_y,
  output logic signed [NORM_W-1:0] out_norm_z,
  output logic [TEX_W-1:0]         out_tex_u,
  output logic [TEX_W-1:0]         out_tex_v,
  output logic [ID_W-1:0]          out_vertex_id,
  output logic [ID_W-1:0]          out_below_id,
  output logic                     out_quad_valid,
  output logic                     out_vertex_valid
);

  localparam int STEPS    = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int DIV_LAT  = TEX_W;
  localparam int COR_LAT  = STEPS + 2;
  localparam int LGT_LAT  = 3;
  localparam int SIDE_LAT = DIV_LAT + COR_LAT + LGT_LAT;
  localparam int UV_LAT   = COR_LAT + LGT_LAT;

  // configuration registers
  logic [RAD_W-1:0]   radius_r;
  logic [COUNT_W-1:0] seg_cnt_r, ring_cnt_r;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= RAD_W'(256);
      seg_cnt_r  <= COUNT_W'(32);
      ring_cnt_r <= COUNT_W'(16);
    end else if (wr_en) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_RADIUS:   radius_r   <= pwdata[RAD_W-1:0];
        REG_SEGMENTS: seg_cnt_r  <= pwdata[COUNT_W-1:0];
        REG_RINGS:    ring_cnt_r <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_RADIUS:   prdata = DATA_W'(radius_r);
      REG_SEGMENTS: prdata = DATA_W'(seg_cnt_r);
      REG_RINGS:    prdata = DATA_W'(ring_cnt_r);
      default:      prdata = '0;
    endcase
  end

  // pipeline enable
  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // index and grid checks at entry
  logic [COUNT_W-1:0]   segs, rings;
  logic [COUNT_W:0]     segs_p1;
  logic [2*COUNT_W:0]   row_base;
  logic [ID_W-1:0]      vid, below;
  side_t                side_in;

  assign segs     = eff_count(seg_cnt_r);
  assign rings    = eff_count(ring_cnt_r);
  assign segs_p1  = {1'b0, segs} + (COUNT_W+1)'(1);
  assign row_base = in_ring_index * segs_p1;
  assign vid      = row_base[ID_W-1:0] + ID_W'(in_seg_index);
  assign below    = vid + ID_W'(segs_p1);

  always_comb begin
    side_in.in_grid = (in_seg_index <= segs) && (in_ring_index <= rings);
    side_in.quad    = (in_seg_index < segs) && (in_ring_index < rings);
    side_in.vid     = vid;
    side_in.below   = below;
  end

  logic  valid_r [SIDE_LAT];
  side_t side_r  [SIDE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIDE_LAT; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int i = 1; i < SIDE_LAT; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < SIDE_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // texture coordinates
  logic [TEX_W-1:0] tex_u, tex_v;

  uvs_div #(.NW(COUNT_W), .QW(TEX_W)) u_div_u (
    .clk (clk),
    .en  (en),
    .num (in_seg_index),
    .den (segs),
    .q   (tex_u)
  );

  uvs_div #(.NW(COUNT_W), .QW(TEX_W)) u_div_v (
    .clk (clk),
    .en  (en),
    .num (in_ring_index),
    .den (rings),
    .q   (tex_v)
  );

  logic [TEX_W-1:0] u_r [UV_LAT];
  logic [TEX_W-1:0] v_r [UV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0] <= tex_u;
      v_r[0] <= tex_v;
      for (int i = 1; i < UV_LAT; i++) begin
        u_r[i] <= u_r[i-1];
        v_r[i] <= v_r[i-1];
      end
    end
  end

  // angles and sin/cos
  logic [PHASE_W-1:0]       theta, phi;
  logic signed [NORM_W-1:0] ct, st, cp, sp;

  assign theta = {tex_u[15:0], 16'b0};
  assign phi   = {tex_v, 15'b0};

  uvs_cordic #(.STEPS(STEPS)) u_cordic_theta (
    .clk   (clk),
    .en    (en),
    .phase (theta),
    .cos_o (ct),
    .sin_o (st)
  );

  uvs_cordic #(.STEPS(STEPS)) u_cordic_phi (
    .clk   (clk),
    .en    (en),
    .phase (phi),
    .cos_o (cp),
    .sin_o (sp)
  );

  // normal and position
  logic signed [NORM_W-1:0] nx, ny, nz;
  logic signed [PROD_W-1:0] px, py, pz;

  uvs_light u_light (
    .clk    (clk),
    .en     (en),
    .ct     (ct),
    .st     (st),
    .cp     (cp),
    .sp     (sp),
    .radius (radius_r),
    .nx     (nx),
    .ny     (ny),
    .nz     (nz),
    .px     (px),
    .py     (py),
    .pz     (pz)
  );

  // output register
  logic signed [POS_W-1:0]  pos_x_r, pos_y_r, pos_z_r;
  logic signed [NORM_W-1:0] norm_x_r, norm_y_r, norm_z_r;
  logic [TEX_W-1:0]         tex_u_r, tex_v_r;
  logic [ID_W-1:0]          vid_r, below_r;
  logic                     quad_r, vvalid_r;
  side_t                    side_o;

  assign side_o = side_r[SIDE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_r[SIDE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_o.in_grid) begin
        pos_x_r  <= px[POS_W+13:14];
        pos_y_r  <= py[POS_W+13:14];
        pos_z_r  <= pz[POS_W+13:14];
        norm_x_r <= nx;
        norm_y_r <= ny;
        norm_z_r <= nz;
        tex_u_r  <= u_r[UV_LAT-1];
        tex_v_r  <= v_r[UV_LAT-1];
        vid_r    <= side_o.vid;
        below_r  <= side_o.below;
        quad_r   <= side_o.quad;
        vvalid_r <= 1'b1;
      end else begin
        pos_x_r  <= '0;
        pos_y_r  <= '0;
        pos_z_r  <= '0;
        norm_x_r <= '0;
        norm_y_r <= '0;
        norm_z_r <= '0;
        tex_u_r  <= '0;
        tex_v_r  <= '0;
        vid_r    <= '0;
        below_r  <= '0;
        quad_r   <= 1'b0;
        vvalid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = pos_x_r;
  assign out_pos_y        = pos_y_r;
  assign out_pos_z        = pos_z_r;
  assign out_norm_x       = norm_x_r;
  assign out_norm_y       = norm_y_r;
  assign out_norm_z       = norm_z_r;
  assign out_tex_u        = tex_u_r;
  assign out_tex_v        = tex_v_r;
  assign out_vertex_id    = vid_r;
  assign out_below_id     = below_r;
  assign out_quad_valid   = quad_r;
  assign out_vertex_valid = vvalid_r;

  // checks
  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_quad_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_quad_valid |-> out_vertex_valid)
    else $error("quad flagged for a point outside the grid");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_norm_y <= 16'sd16384) && (out_norm_y >= -16'sd16384) &&
                  (out_norm_x <= 16'sd16384) && (out_norm_x >= -16'sd16384))
    else $error("normal component out of range");

endmodule

### rtl/core/uvs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_div
// pipelined restoring divider, one quotient bit per stage,
// q = floor(num * 2^(QW-1) / den) for num <= den
// ----------------------------------------------------------------------------
module uvs_div
  import uvs_pkg::*;
#(
  parameter int NW = COUNT_W,
  parameter int QW = TEX_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic [QW-1:0] q
);

  logic [NW-1:0] rem_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW:0]   trial;
    logic          ge;
    logic [NW:0]   diff;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign trial = {1'b0, num};
      assign q_nxt = QW'(ge);
    end else begin : g_rest
      assign trial = {rem_r[k-1], 1'b0};
      assign q_nxt = {q_r[k-1][QW-2:0], ge};
    end

    assign ge      = (trial >= {1'b0, den});
    assign diff    = trial - {1'b0, den};
    assign rem_nxt = ge ? diff[NW-1:0] : trial[NW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
      end
    end
  end

  assign q = q_r[QW-1];

endmodule

### rtl/core/uvs_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_cordic
// pipelined rotation-mode cordic: quadrant fold, one micro-rotation per
// stage, then quadrant unfold and cut to q1.14
// ----------------------------------------------------------------------------
module uvs_cordic
  import uvs_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [PHASE_W-1:0]       phase,
  output logic signed [NORM_W-1:0] cos_o,
  output logic signed [NORM_W-1:0] sin_o
);

  typedef enum logic [1:0] {QD_0 = 2'd0, QD_1 = 2'd1, QD_2 = 2'd2, QD_3 = 2'd3} quad_t;

  logic [PHASE_W-1:0]   sum;
  logic [1:0]           qd;
  logic [PHASE_W-1:0]   resid;
  logic signed [CW-1:0] fz_r;
  logic [1:0]           fq_r;

  logic signed [CW-1:0] x_r [STEPS];
  logic signed [CW-1:0] y_r [STEPS];
  logic signed [CW-1:0] z_r [STEPS];
  logic [1:0]           q_r [STEPS];

  logic signed [CW-1:0]     c_sel, s_sel;
  logic signed [CW-1:0]     c_sh, s_sh;
  logic signed [NORM_W-1:0] cos_r, sin_r;

  // fold to a residual within an eighth of a turn
  assign sum   = phase + 32'h2000_0000;
  assign qd    = sum[PHASE_W-1:PHASE_W-2];
  assign resid = phase - {qd, 30'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      fz_r <= {{(CW-PHASE_W){resid[PHASE_W-1]}}, resid};
      fq_r <= qd;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] xi, yi, zi;
    logic [1:0]           qi;
    logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;

    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = fz_r;
      assign qi = fq_r;
    end else begin : g_rest
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign qi = q_r[i-1];
    end

    always_comb begin
      if (zi >= 0) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
        z_nxt = zi - atan_turn(i);
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
        z_nxt = zi + atan_turn(i);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
        q_r[i] <= qi;
      end
    end
  end

  always_comb begin
    case (quad_t'(q_r[STEPS-1]))
      QD_0: begin
        c_sel = x_r[STEPS-1];
        s_sel = y_r[STEPS-1];
      end
      QD_1: begin
        c_sel = -y_r[STEPS-1];
        s_sel = x_r[STEPS-1];
      end
      QD_2: begin
        c_sel = -x_r[STEPS-1];
        s_sel = -y_r[STEPS-1];
      end
      default: begin
        c_sel = y_r[STEPS-1];
        s_sel = -x_r[STEPS-1];
      end
    endcase
    c_sh = c_sel >>> 16;
    s_sh = s_sel >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= clamp_norm(c_sh);
      sin_r <= clamp_norm(s_sh);
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

### rtl/core/uvs_light.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_light
// normal from the two angle pairs, then position products with the radius
// ----------------------------------------------------------------------------
module uvs_light
  import uvs_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [NORM_W-1:0] ct,
  input  logic signed [NORM_W-1:0] st,
  input  logic signed [NORM_W-1:0] cp,
  input  logic signed [NORM_W-1:0] sp,
  input  logic [RAD_W-1:0]         radius,
  output logic signed [NORM_W-1:0] nx,
  output logic signed [NORM_W-1:0] ny,
  output logic signed [NORM_W-1:0] nz,
  output logic signed [PROD_W-1:0] px,
  output logic signed [PROD_W-1:0] py,
  output logic signed [PROD_W-1:0] pz
);

  logic signed [2*NORM_W-1:0] mx_r, mz_r;
  logic signed [NORM_W-1:0]   ny1_r;
  logic signed [NORM_W-1:0]   nx2_r, ny2_r, nz2_r;
  logic signed [NORM_W-1:0]   nx3_r, ny3_r, nz3_r;
  logic signed [PROD_W-1:0]   px_r, py_r, pz_r;
  logic signed [RAD_W:0]      rad_s;

  assign rad_s = {1'b0, radius};

  always_ff @(posedge clk) begin
    if (en) begin
      mx_r  <= ct * sp;
      mz_r  <= st * sp;
      ny1_r <= cp;

      nx2_r <= clamp_norm(CW'(mx_r >>> 14));
      nz2_r <= clamp_norm(CW'(mz_r >>> 14));
      ny2_r <= ny1_r;

      px_r  <= rad_s * nx2_r;
      py_r  <= rad_s * ny2_r;
      pz_r  <= rad_s * nz2_r;
      nx3_r <= nx2_r;
      ny3_r <= ny2_r;
      nz3_r <= nz2_r;
    end
  end

  assign nx = nx3_r;
  assign ny = ny3_r;
  assign nz = nz3_r;
  assign px = px_r;
  assign py = py_r;
  assign pz = pz_r;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the uv sphere vertex generator: points on and off the grid are streamed
// in with random gaps and output stalls, each vertex is predicted by an in-bench
// fixed point cordic model and compared field by field, in order
// ----------------------------------------------------------------------------
module tb_top
  import uvs_pkg::*;
();

  typedef struct {
    logic signed [POS_W-1:0]  px, py, pz;
    logic signed [NORM_W-1:0] nx, ny, nz;
    logic [TEX_W-1:0]         u, v;
    logic [ID_W-1:0]          vid, bid;
    logic                     quad, inside_grid;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COUNT_W-1:0] in_seg_index = '0, in_ring_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [NORM_W-1:0] out_norm_x, out_norm_y, out_norm_z;
  logic [TEX_W-1:0] out_tex_u, out_tex_v;
  logic [ID_W-1:0] out_vertex_id, out_below_id;
  logic out_quad_valid, out_vertex_valid;

  vertex_t expected_vertices[$];
  int error_count = 0;
  longint radius_q88 = 256, segment_cfg = 32, ring_cfg = 16;
  int latency_cycles = CORDIC_STEPS_DEF + 23;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  uv_sphere_vertex_generator dut (.*);

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint floor_shr(longint a, int s);
    return a >>> s;
  endfunction

  function automatic longint clip_unit(longint a);
    if (a > 16384) return 16384;
    if (a < -16384) return -16384;
    return a;
  endfunction

  function automatic longint div_count(longint c);
    if (c == 0) return 1;
    if (c > MAX_DIVISIONS) return MAX_DIVISIONS;
    return c;
  endfunction

  function automatic longint turn_atan(int i);
    longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  task automatic sin_cos_q14(input logic [31:0] phase, output longint c,
                             output longint s);
    logic [31:0] q, r;
    longint z, x, y, dx, dy, cc, ss;
    q = ((phase + 32'h2000_0000) >> 30) & 32'd3;
    r = phase - q * 32'h4000_0000;
    z = longint'($signed(r));
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= turn_atan(i);
      end else begin
        x += dx; y -= dy; z += turn_atan(i);
      end
    end
    case (q)
      0: begin cc = x; ss = y; end
      1: begin cc = -y; ss = x; end
      2: begin cc = -x; ss = -y; end
      default: begin cc = y; ss = -x; end
    endcase
    c = clip_unit(floor_shr(cc, 16));
    s = clip_unit(floor_shr(ss, 16));
  endtask

  task automatic predict_vertex(input longint x, input longint y, output vertex_t e);
    longint segs, rings, u, v, ct, st, cp, sp, nx, nz, vid;
    segs = div_count(segment_cfg);
    rings = div_count(ring_cfg);
    e = '{default: '0};
    if (x > segs || y > rings) return;
    u = (x << 16) / segs;
    v = (y << 16) / rings;
    sin_cos_q14(32'(u << 16), ct, st);
    sin_cos_q14(32'(v << 15), cp, sp);
    nx = clip_unit(floor_shr(ct * sp, 14));
    nz = clip_unit(floor_shr(st * sp, 14));
    vid = y * (segs + 1) + x;
    e.px = POS_W'(floor_shr(radius_q88 * nx, 14));
    e.py = POS_W'(floor_shr(radius_q88 * cp, 14));
    e.pz = POS_W'(floor_shr(radius_q88 * nz, 14));
    e.nx = NORM_W'(nx);
    e.ny = NORM_W'(cp);
    e.nz = NORM_W'(nz);
    e.u = TEX_W'(u);
    e.v = TEX_W'(v);
    e.vid = ID_W'(vid);
    e.bid = ID_W'(vid + segs + 1);
    e.quad = (x < segs && y < rings);
    e.inside_grid = 1'b1;
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input longint value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RADIUS: radius_q88 = value & 16'hFFFF;
      REG_SEGMENTS: segment_cfg = value & 11'h7FF;
      default: ring_cfg = value & 11'h7FF;
    endcase
  endtask

  task automatic drain_pipeline();
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (latency_cycles + 4) @(posedge clk);
  endtask

  task automatic configure(input longint rad, input longint segs, input longint rings);
    drain_pipeline();
    write_reg(REG_RADIUS, rad);
    write_reg(REG_SEGMENTS, segs);
    write_reg(REG_RINGS, rings);
  endtask

  // one transaction on the input channel
  task automatic send_point(input longint x, input longint y, input bit gaps);
    vertex_t e;
    int idle;
    idle = gaps ? $urandom_range(0, 13) : 0;
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_seg_index <= COUNT_W'(x);
    in_ring_index <= COUNT_W'(y);
    predict_vertex(x & 11'h7FF, y & 11'h7FF, e);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_vertices = {expected_vertices, e};
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  task automatic test_reset_grid();
    longint s, r;
    s = div_count(segment_cfg);
    r = div_count(ring_cfg);
    send_point(0, 0, 0); send_point(s, 0, 0); send_point(0, r, 0);
    send_point(s, r, 0); send_point(s / 2, r / 2, 1); send_point(s + 1, 0, 1);
    send_point(0, r + 1, 0); send_point(2047, 2047, 0); send_point(s - 1, r - 1, 1);
    end_burst();
  endtask

  task automatic test_extremes();
    configure(65535, 1024, 1024);
    send_point(0, 0, 0); send_point(1024, 1024, 0); send_point(1023, 1023, 0);
    send_point(256, 512, 1); send_point(768, 333, 0); send_point(1025, 5, 0);
    end_burst();
    configure(0, 0, 0);
    send_point(0, 0, 0); send_point(1, 1, 0); send_point(1, 0, 1); send_point(2, 0, 0);
    end_burst();
    configure(12345, 2047, 1500);
    send_point(1024, 1024, 0); send_point(1025, 1024, 0); send_point(512, 700, 1);
    end_burst();
  endtask

  task automatic test_random_grids();
    longint s, r;
    for (int phase = 0; phase < 12; phase++) begin
      configure($urandom_range(0, 65535), $urandom_range(0, 7) == 0 ?
                $urandom_range(0, 2047) : $urandom_range(1, 64),
                $urandom_range(0, 7) == 0 ? $urandom_range(0, 2047) :
                $urandom_range(1, 64));
      s = div_count(segment_cfg);
      r = div_count(ring_cfg);
      for (int n = 0; n < 128; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_point($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 3) == 0);
        else
          send_point($urandom_range(0, s), $urandom_range(0, r), $urandom_range(0, 3) == 0);
      end
      end_burst();
    end
  endtask

  // output stall pattern, with calm stretches
  initial begin
    int hold;
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      out_stall <= (hold != 0);
      repeat (hold + 1) @(posedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        e = expected_vertices.pop_front();
        if (out_pos_x !== e.px) report_mismatch("pos_x", out_pos_x, e.px);
        if (out_pos_y !== e.py) report_mismatch("pos_y", out_pos_y, e.py);
        if (out_pos_z !== e.pz) report_mismatch("pos_z", out_pos_z, e.pz);
        if (out_norm_x !== e.nx) report_mismatch("norm_x", out_norm_x, e.nx);
        if (out_norm_y !== e.ny) report_mismatch("norm_y", out_norm_y, e.ny);
        if (out_norm_z !== e.nz) report_mismatch("norm_z", out_norm_z, e.nz);
        if (out_tex_u !== e.u) report_mismatch("tex_u", out_tex_u, e.u);
        if (out_tex_v !== e.v) report_mismatch("tex_v", out_tex_v, e.v);
        if (out_vertex_id !== e.vid) report_mismatch("vertex_id", out_vertex_id, e.vid);
        if (out_below_id !== e.bid) report_mismatch("below_id", out_below_id, e.bid);
        if (out_quad_valid !== e.quad) report_mismatch("quad_valid", out_quad_valid, e.quad);
        if (out_vertex_valid !== e.inside_grid)
          report_mismatch("vertex_valid", out_vertex_valid, e.inside_grid);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_grid();
    test_extremes();
    test_random_grids();
    drain_pipeline();
    if (expected_vertices.size() != 0)
      report_mismatch("missing transactions", 0, expected_vertices.size());
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/uvs_pkg.sv
rtl/core/uvs_div.sv
rtl/core/uvs_cordic.sv
rtl/core/uvs_light.sv
rtl/core/uv_sphere_vertex_generator.sv
verif/tb_top.sv
